// File: hw/rtl/grapq_pkg.sv
// Shared constants, types and command/status bundles of the grid range-add point-query block.
`default_nettype none
package grapq_pkg;

   // Default tree sizes.
   localparam int MAX_ROWS_DEF = 64;
   localparam int MAX_COLS_DEF = 64;

   // Fixed field widths.
   localparam int DATA_W  = 32;
   localparam int COORD_W = 7;
   localparam int CFG_W   = 7;
   localparam int CSR_IX_W = 1;

   // Reset value of both size registers.
   localparam logic [CFG_W-1:0] SIZE_RESET = 7'd64;

   // Opcodes.
   localparam logic OP_ADD   = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // Register indexes.
   localparam logic [CSR_IX_W-1:0] CSR_ROWS = 1'b0;
   localparam logic [CSR_IX_W-1:0] CSR_COLS = 1'b1;

   // Controller states.
   typedef enum logic [5:0] {
      ST_CLEAR  = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_OUTER  = 6'b000100,
      ST_INNER  = 6'b001000,
      ST_UPDATE = 6'b010000,
      ST_RESP   = 6'b100000
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic o_start;
      logic o_adv;
      logic i_start;
      logic i_adv;
      logic mem_rd;
      logic mem_wr;
      logic acc_add;
      logic clr_wr;
      logic rsp_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic req_query;
      logic add_empty;
      logic is_query;
      logic o_cover;
      logic o_last;
      logic i_cover;
      logic i_last;
      logic clr_last;
   } status_type;

endpackage
`default_nettype wire

// File: hw/rtl/grapq_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module grapq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic                     we,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// File: hw/rtl/grapq_walk.sv
// Segment tree walker: steps through the nodes of one range decomposition in depth-first order.
`default_nettype none
module grapq_walk
   import grapq_pkg::*;
#(
   parameter int MAXN = 64
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic                          adv,
   input  wire logic [$clog2(MAXN+1)-1:0]     size,
   input  wire logic [$clog2(MAXN+1)-1:0]     lo,
   input  wire logic [$clog2(MAXN+1)-1:0]     hi,
   output logic      [$clog2(4*MAXN)-1:0]     node,
   output logic                               covered,
   output logic                               last
);

   localparam int CW = $clog2(MAXN + 1);
   localparam int NW = $clog2(4 * MAXN);
   localparam int SD = $clog2(MAXN) + 2;
   localparam int IX = $clog2(SD);
   localparam int PW = $clog2(SD + 1);

   logic [NW-1:0] node_ff, node_in;
   logic [CW-1:0] l_ff, l_in, r_ff, r_in;
   logic [CW-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [PW-1:0] sp_ff, sp_in;
   logic [NW-1:0] stk_node_ff [SD];
   logic [CW-1:0] stk_l_ff [SD];
   logic [CW-1:0] stk_r_ff [SD];
   logic          push;
   logic [CW:0]   lr_sum;
   logic [CW-1:0] mid;
   logic          go_l, go_r;
   logic [NW-1:0] left_node, right_node;
   logic [PW-1:0] sp_m1;
   logic [IX-1:0] push_ix, pop_ix;

   // Split point and child choice of the current node.
   always_comb begin
      lr_sum     = {1'b0, l_ff} + {1'b0, r_ff};
      mid        = lr_sum[CW:1];
      covered    = (lo_ff <= l_ff) && (r_ff <= hi_ff);
      go_l       = lo_ff <= mid;
      go_r       = mid < hi_ff;
      left_node  = {node_ff[NW-2:0], 1'b0};
      right_node = {node_ff[NW-2:0], 1'b1};
      sp_m1      = sp_ff - PW'(1);
      push_ix    = sp_ff[IX-1:0];
      pop_ix     = sp_m1[IX-1:0];
      last       = covered && (sp_ff == '0);
   end

   // Next node: descend, or take the pending right sibling from the stack.
   always_comb begin
      node_in = node_ff;
      l_in    = l_ff;
      r_in    = r_ff;
      lo_in   = lo_ff;
      hi_in   = hi_ff;
      sp_in   = sp_ff;
      push    = 1'b0;
      if (start) begin
         node_in = NW'(1);
         l_in    = CW'(1);
         r_in    = size;
         lo_in   = lo;
         hi_in   = hi;
         sp_in   = '0;
      end else if (adv) begin
         if (covered) begin
            node_in = stk_node_ff[pop_ix];
            l_in    = stk_l_ff[pop_ix];
            r_in    = stk_r_ff[pop_ix];
            sp_in   = sp_m1;
         end else if (go_l) begin
            node_in = left_node;
            r_in    = mid;
            if (go_r) begin
               push  = 1'b1;
               sp_in = sp_ff + PW'(1);
            end
         end else begin
            node_in = right_node;
            l_in    = mid + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff <= '0;
      end else begin
         sp_ff <= sp_in;
      end
   end

   always_ff @(posedge clock) begin
      node_ff <= node_in;
      l_ff    <= l_in;
      r_ff    <= r_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      if (push) begin
         stk_node_ff[push_ix] <= right_node;
         stk_l_ff[push_ix]    <= mid + CW'(1);
         stk_r_ff[push_ix]    <= r_ff;
      end
   end

   assign node = node_ff;

endmodule
`default_nettype wire

// File: hw/rtl/grapq_dp.sv
// Datapath: size registers, range clamping, the two tree walkers, the tag memory and the sum.
`default_nettype none
module grapq_dp
   import grapq_pkg::*;
#(
   parameter int MAX_ROWS = MAX_ROWS_DEF,
   parameter int MAX_COLS = MAX_COLS_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cmd_type             cmd,
   output status_type               sts,
   input  wire logic                csr_wr_en,
   input  wire logic [CSR_IX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]    csr_wdata,
   input  wire logic                req_opcode,
   input  wire logic [COORD_W-1:0]  req_row_lo,
   input  wire logic [COORD_W-1:0]  req_row_hi,
   input  wire logic [COORD_W-1:0]  req_col_lo,
   input  wire logic [COORD_W-1:0]  req_col_hi,
   input  wire logic signed [DATA_W-1:0] req_delta,
   input  wire logic [COORD_W-1:0]  req_query_row,
   input  wire logic [COORD_W-1:0]  req_query_col,
   output logic signed [DATA_W-1:0] rsp_cell_value
);

   localparam int RCW = $clog2(MAX_ROWS + 1);
   localparam int CCW = $clog2(MAX_COLS + 1);
   localparam int RXW = (RCW > CFG_W) ? RCW : CFG_W;
   localparam int CXW = (CCW > CFG_W) ? CCW : CFG_W;
   localparam int ONW = $clog2(4 * MAX_ROWS);
   localparam int INW = $clog2(4 * MAX_COLS);
   localparam int AW  = ONW + INW;
   localparam int DEPTH = 1 << AW;

   // Clamp a row value into 1..n.
   function automatic logic [RCW-1:0] clamp_row(input logic [CFG_W-1:0] v,
                                                input logic [RXW-1:0] n);
      logic [RXW-1:0] vx;
      logic [RXW-1:0] res;
      vx = RXW'(v);
      if (vx == '0) res = RXW'(1);
      else if (vx > n) res = n;
      else res = vx;
      return res[RCW-1:0];
   endfunction

   // Clamp a column value into 1..n.
   function automatic logic [CCW-1:0] clamp_col(input logic [CFG_W-1:0] v,
                                                input logic [CXW-1:0] n);
      logic [CXW-1:0] vx;
      logic [CXW-1:0] res;
      vx = CXW'(v);
      if (vx == '0) res = CXW'(1);
      else if (vx > n) res = n;
      else res = vx;
      return res[CCW-1:0];
   endfunction

   logic [CFG_W-1:0]  rows_ff, cols_ff;
   logic [RCW-1:0]    nrows;
   logic [CCW-1:0]    ncols;
   logic [RCW-1:0]    rlo, rhi, qrow, o_lo, o_hi;
   logic [CCW-1:0]    clo, chi, qcol;
   logic [CCW-1:0]    clo_ff, chi_ff;
   logic              op_ff;
   logic [DATA_W-1:0] delta_ff;
   logic [DATA_W-1:0] acc_ff, acc_in;
   logic [DATA_W-1:0] rsp_ff;
   logic [AW-1:0]     clr_cnt_ff;
   logic [ONW-1:0]    onode;
   logic [INW-1:0]    inode;
   logic [AW-1:0]     mem_addr;
   logic [DATA_W-1:0] mem_rdata, mem_wdata;
   logic              mem_we;
   logic              o_cover, o_last, i_cover, i_last;

   // Size registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= SIZE_RESET;
         cols_ff <= SIZE_RESET;
      end else if (csr_wr_en) begin
         if (csr_index == CSR_ROWS) rows_ff <= csr_wdata;
         if (csr_index == CSR_COLS) cols_ff <= csr_wdata;
      end
   end

   // Effective sizes and clamped coordinates of the incoming word.
   always_comb begin
      nrows = clamp_row(rows_ff, RXW'(MAX_ROWS));
      ncols = clamp_col(cols_ff, CXW'(MAX_COLS));
      rlo   = clamp_row(req_row_lo, RXW'(nrows));
      rhi   = clamp_row(req_row_hi, RXW'(nrows));
      qrow  = clamp_row(req_query_row, RXW'(nrows));
      clo   = clamp_col(req_col_lo, CXW'(ncols));
      chi   = clamp_col(req_col_hi, CXW'(ncols));
      qcol  = clamp_col(req_query_col, CXW'(ncols));
      o_lo  = (req_opcode == OP_QUERY) ? qrow : rlo;
      o_hi  = (req_opcode == OP_QUERY) ? qrow : rhi;
   end

   // Word registers, accumulator and response data.
   always_comb begin
      acc_in = acc_ff;
      if (cmd.load) acc_in = '0;
      else if (cmd.acc_add) acc_in = acc_ff + mem_rdata;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_opcode;
         delta_ff <= req_delta;
         clo_ff   <= (req_opcode == OP_QUERY) ? qcol : clo;
         chi_ff   <= (req_opcode == OP_QUERY) ? qcol : chi;
      end
      acc_ff <= acc_in;
      if (cmd.rsp_load) rsp_ff <= acc_ff;
   end

   // Clearing sweep address after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clr_wr) begin
         clr_cnt_ff <= clr_cnt_ff + AW'(1);
      end
   end

   // Row tree and column tree walkers.
   grapq_walk #(.MAXN(MAX_ROWS)) u_owalk (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.o_start),
      .adv     (cmd.o_adv),
      .size    (nrows),
      .lo      (o_lo),
      .hi      (o_hi),
      .node    (onode),
      .covered (o_cover),
      .last    (o_last)
   );

   grapq_walk #(.MAXN(MAX_COLS)) u_iwalk (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.i_start),
      .adv     (cmd.i_adv),
      .size    (ncols),
      .lo      (clo_ff),
      .hi      (chi_ff),
      .node    (inode),
      .covered (i_cover),
      .last    (i_last)
   );

   // Tag memory: sweep writes zeros, updates write tag plus delta.
   always_comb begin
      mem_addr  = cmd.clr_wr ? clr_cnt_ff : {onode, inode};
      mem_we    = cmd.clr_wr || cmd.mem_wr;
      mem_wdata = cmd.clr_wr ? '0 : (mem_rdata + delta_ff);
   end

   grapq_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_tags (
      .clock (clock),
      .addr  (mem_addr),
      .we    (mem_we),
      .wdata (mem_wdata),
      .re    (cmd.mem_rd),
      .rdata (mem_rdata)
   );

   // Status to the controller.
   always_comb begin
      sts.req_query = req_opcode == OP_QUERY;
      sts.add_empty = (rlo > rhi) || (clo > chi);
      sts.is_query  = op_ff == OP_QUERY;
      sts.o_cover   = o_cover;
      sts.o_last    = o_last;
      sts.i_cover   = i_cover;
      sts.i_last    = i_last;
      sts.clr_last  = &clr_cnt_ff;
   end

   assign rsp_cell_value = rsp_ff;

endmodule
`default_nettype wire

// File: hw/rtl/grapq_ctrl.sv
// Controller state machine: clearing sweep, tree walks, tag updates and response handshake.
`default_nettype none
module grapq_ctrl
   import grapq_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output cmd_type         cmd,
   input  wire status_type sts
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   // Next state and commands.
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (sts.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (sts.req_query || !sts.add_empty) begin
                  cmd.o_start = 1'b1;
                  state_in    = ST_OUTER;
               end
            end
         end
         ST_OUTER: begin
            if (sts.is_query || sts.o_cover) begin
               cmd.i_start = 1'b1;
               state_in    = ST_INNER;
            end else begin
               cmd.o_adv = 1'b1;
            end
         end
         ST_INNER: begin
            if (sts.is_query || sts.i_cover) begin
               cmd.mem_rd = 1'b1;
               state_in   = ST_UPDATE;
            end else begin
               cmd.i_adv = 1'b1;
            end
         end
         ST_UPDATE: begin
            if (sts.is_query) cmd.acc_add = 1'b1;
            else cmd.mem_wr = 1'b1;
            if (sts.i_last) begin
               if (sts.o_last) begin
                  state_in = sts.is_query ? ST_RESP : ST_IDLE;
               end else begin
                  cmd.o_adv = 1'b1;
                  state_in  = ST_OUTER;
               end
            end else begin
               cmd.i_adv = 1'b1;
               state_in  = ST_INNER;
            end
         end
         ST_RESP: begin
            if (slot_free) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

// File: hw/rtl/grid_range_add_point_query_core.sv
// Top level of the grid range-add point-query block.
// An add takes the word, then walks the row tree and, inside each covering row node, the column
// tree, writing tag plus delta to each covering column node. A query walks the row path and,
// in each row node on it, the column path, adding up each tag, then gives the response.
// One word is in work at a time: a new word is taken only after the last one is through.
// After reset the tag memory is swept to zero, all 2^(ONW+INW) entries (65536 at default sizes).
`default_nettype none
module grid_range_add_point_query_core
   import grapq_pkg::*;
#(
   parameter int MAX_ROWS = MAX_ROWS_DEF,
   parameter int MAX_COLS = MAX_COLS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic                     req_opcode,
   input  wire logic [COORD_W-1:0]       req_row_lo,
   input  wire logic [COORD_W-1:0]       req_row_hi,
   input  wire logic [COORD_W-1:0]       req_col_lo,
   input  wire logic [COORD_W-1:0]       req_col_hi,
   input  wire logic signed [DATA_W-1:0] req_delta,
   input  wire logic [COORD_W-1:0]       req_query_row,
   input  wire logic [COORD_W-1:0]       req_query_col,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic signed [DATA_W-1:0]      rsp_cell_value,
   input  wire logic                     csr_wr_en,
   input  wire logic [CSR_IX_W-1:0]      csr_index,
   input  wire logic [CFG_W-1:0]         csr_wdata
);

   cmd_type    cmd;
   status_type sts;

   // Controller.
   grapq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // Datapath.
   grapq_dp #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_opcode     (req_opcode),
      .req_row_lo     (req_row_lo),
      .req_row_hi     (req_row_hi),
      .req_col_lo     (req_col_lo),
      .req_col_hi     (req_col_hi),
      .req_delta      (req_delta),
      .req_query_row  (req_query_row),
      .req_query_col  (req_query_col),
      .rsp_cell_value (rsp_cell_value)
   );

endmodule
`default_nettype wire

// File: hw/rtl/grapq_checker.sv
// Port-level checker of the grid range-add point-query block, bound to the top level.
`default_nettype none
module grapq_checker
   import grapq_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic              req_opcode,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic [DATA_W-1:0] rsp_cell_value
);

   // Reset starts the clearing sweep: no word is taken and no result is shown.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("block ready or result shown right after reset");

   // A query keeps the block busy in the cycle after it is taken.
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_opcode == OP_QUERY)) |=> !req_ready)
      else $error("block ready right after taking a query");

   // A stalled result word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_cell_value))
      else $error("result word dropped or changed while stalled");

endmodule

bind grid_range_add_point_query_core grapq_checker u_grapq_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .req_opcode     (req_opcode),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_cell_value (rsp_cell_value)
);
`default_nettype wire

// File: dv/tb_grid_range_add_point_query_core.sv
// Self-checking testbench of the grid range-add point-query block.
`timescale 1ns / 100ps
`default_nettype none
module tb_grid_range_add_point_query_core;
   import grapq_pkg::*;

   localparam int MAXR = 64;
   localparam int MAXC = 64;
   localparam int ONODES = 4 * MAXR;
   localparam int INODES = 4 * MAXC;
   localparam int STALL_LIMIT = 200000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_opcode = OP_ADD;
   logic [COORD_W-1:0] req_row_lo = '0, req_row_hi = '0, req_col_lo = '0, req_col_hi = '0;
   logic signed [DATA_W-1:0] req_delta = '0;
   logic [COORD_W-1:0] req_query_row = '0, req_query_col = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [DATA_W-1:0] rsp_cell_value;
   logic csr_wr_en = 1'b0;
   logic [CSR_IX_W-1:0] csr_index = CSR_ROWS;
   logic [CFG_W-1:0] csr_wdata = '0;

   grid_range_add_point_query_core u_dut (.*);

   always #4 clock = ~clock;

   // Shadow of the tag tree and the size registers.
   logic [31:0] shadow_tags [ONODES*INODES];
   logic [6:0] rows_reg, cols_reg;
   logic [31:0] cell_values_due [$];
   int mismatch_count = 0;
   int idle_cycles = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_off_cycles = 0;

   function automatic int clamp(int v, int n);
      if (v < 1) return 1;
      if (v > n) return n;
      return v;
   endfunction

   function automatic int eff_rows();
      return clamp(rows_reg, MAXR);
   endfunction

   function automatic int eff_cols();
      return clamp(cols_reg, MAXC);
   endfunction

   // Tag every covering column node under one covering row node.
   function automatic void tag_cols(int onode, int node, int l, int r, int lo, int hi,
                                    logic [31:0] d);
      int mid;
      if (node >= INODES) return;
      if (lo <= l && r <= hi) begin
         shadow_tags[onode*INODES+node] += d;
         return;
      end
      mid = (l + r) >> 1;
      if (lo <= mid) tag_cols(onode, node*2, l, mid, lo, hi, d);
      if (mid < hi) tag_cols(onode, node*2+1, mid+1, r, lo, hi, d);
   endfunction

   function automatic void tag_rows(int node, int l, int r, int rlo, int rhi, int clo, int chi,
                                    logic [31:0] d);
      int mid;
      if (node >= ONODES) return;
      if (rlo <= l && r <= rhi) begin
         tag_cols(node, 1, 1, eff_cols(), clo, chi, d);
         return;
      end
      mid = (l + r) >> 1;
      if (rlo <= mid) tag_rows(node*2, l, mid, rlo, rhi, clo, chi, d);
      if (mid < rhi) tag_rows(node*2+1, mid+1, r, rlo, rhi, clo, chi, d);
   endfunction

   // Sum of tags along the row path and, in each row node, the column path.
   function automatic logic [31:0] cell_sum(int row, int col);
      logic [31:0] sum;
      int onode, ol, orr, inode, il, ir, mid;
      sum = '0;
      onode = 1; ol = 1; orr = eff_rows();
      while (onode < ONODES) begin
         inode = 1; il = 1; ir = eff_cols();
         while (inode < INODES) begin
            sum += shadow_tags[onode*INODES+inode];
            if (il == ir) break;
            mid = (il + ir) >> 1;
            if (col <= mid) begin inode = inode*2; ir = mid; end
            else begin inode = inode*2+1; il = mid+1; end
         end
         if (ol == orr) break;
         mid = (ol + orr) >> 1;
         if (row <= mid) begin onode = onode*2; orr = mid; end
         else begin onode = onode*2+1; ol = mid+1; end
      end
      return sum;
   endfunction

   // Predict one accepted word.
   function automatic void predict(logic op, int rlo, int rhi, int clo, int chi,
                                   logic [31:0] d, int qr, int qc);
      int nr, nc;
      nr = eff_rows();
      nc = eff_cols();
      if (op == OP_ADD) begin
         rlo = clamp(rlo, nr); rhi = clamp(rhi, nr);
         clo = clamp(clo, nc); chi = clamp(chi, nc);
         if (rlo <= rhi && clo <= chi) tag_rows(1, 1, nr, rlo, rhi, clo, chi, d);
      end else begin
         cell_values_due.push_back(cell_sum(clamp(qr, nr), clamp(qc, nc)));
      end
   endfunction

   // Result checker and watchdog.
   always @(posedge clock) begin
      logic [31:0] want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (cell_values_due.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("ERROR: unexpected result word, cell_value %0d", rsp_cell_value);
            end else begin
               want = cell_values_due.pop_front();
               if (rsp_cell_value !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("ERROR: cell_value expected %0d actual %0d",
                              $signed(want), rsp_cell_value);
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("FAIL grid_range_add_point_query_core");
            $finish;
         end
      end
   end

   // Receiver: random stalls plus an optional long hold-off.
   always @(negedge clock) begin
      if (hold_off_cycles > 0) begin
         hold_off_cycles--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Send one word; the predictor runs at its acceptance. Valid is dropped only when the
   // sender idles or the traffic is drained.
   task automatic send_word(logic op, int rlo, int rhi, int clo, int chi,
                            logic [31:0] d, int qr, int qc);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
         while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_row_lo <= COORD_W'(rlo); req_row_hi <= COORD_W'(rhi);
      req_col_lo <= COORD_W'(clo); req_col_hi <= COORD_W'(chi);
      req_delta <= d;
      req_query_row <= COORD_W'(qr); req_query_col <= COORD_W'(qc);
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict(op, rlo, rhi, clo, chi, d, qr, qc);
      @(negedge clock);
   endtask

   task automatic add_rect(int rlo, int rhi, int clo, int chi, logic [31:0] d);
      send_word(OP_ADD, rlo, rhi, clo, chi, d, $urandom_range(127), $urandom_range(127));
   endtask

   task automatic query_cell(int r, int c);
      send_word(OP_QUERY, $urandom_range(127), $urandom_range(127), $urandom_range(127),
                $urandom_range(127), $urandom, r, c);
   endtask

   // Stop offering, wait for all results, then for the last add to finish.
   task automatic drain();
      req_valid <= 1'b0;
      while (cell_values_due.size() != 0) @(negedge clock);
      repeat (3000) @(negedge clock);
   endtask

   task automatic write_size(logic [CSR_IX_W-1:0] ix, logic [6:0] v);
      csr_wr_en <= 1'b1;
      csr_index <= ix;
      csr_wdata <= v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
      if (ix == CSR_ROWS) rows_reg = v;
      else cols_reg = v;
   endtask

   task automatic random_word(int nr, int nc);
      int r0, r1, c0, c1;
      if ($urandom_range(9) < 8) begin
         r0 = $urandom_range(nr, 1); r1 = $urandom_range(nr, 1);
         c0 = $urandom_range(nc, 1); c1 = $urandom_range(nc, 1);
      end else begin
         r0 = $urandom_range(127); r1 = $urandom_range(127);
         c0 = $urandom_range(127); c1 = $urandom_range(127);
      end
      if ($urandom_range(1)) add_rect(r0, r1, c0, c1, $urandom);
      else if ($urandom_range(5) == 0) query_cell($urandom_range(127), $urandom_range(127));
      else query_cell($urandom_range(nr, 1), $urandom_range(nc, 1));
   endtask

   // Extremes of fields, clamping, empty ranges, and the delta limits.
   task automatic test_directed();
      add_rect(1, 64, 1, 64, 32'h7FFF_FFFF);
      query_cell(1, 1);
      add_rect(1, 1, 64, 64, 32'h8000_0000);
      query_cell(1, 64);
      query_cell(64, 64);
      add_rect(0, 127, 0, 127, 32'hFFFF_FFFF);
      query_cell(0, 0);
      query_cell(127, 127);
      add_rect(40, 10, 1, 64, 32'h1234_5678);
      add_rect(1, 64, 50, 20, 32'h1111_1111);
      query_cell(30, 30);
      add_rect(33, 33, 17, 48, 32'h5555_5555);
      add_rect(127, 127, 127, 127, 32'hAAAA_AAAA);
      query_cell(33, 17);
      query_cell(64, 64);
      query_cell(32, 16);
   endtask

   task automatic test_random(int n);
      int nr, nc;
      nr = eff_rows();
      nc = eff_cols();
      repeat (n) random_word(nr, nc);
   endtask

   // Size changes, including out-of-range values, with old tags kept.
   task automatic test_sizes();
      logic [6:0] sizes [8] = '{7'd1, 7'd0, 7'd127, 7'd64, 7'd5, 7'd37, 7'd2, 7'd64};
      for (int i = 0; i < 8; i++) begin
         drain();
         write_size(CSR_ROWS, sizes[i]);
         write_size(CSR_COLS, sizes[(i+3) % 8]);
         query_cell(1, 1);
         query_cell(127, 127);
         test_random(40);
      end
   endtask

   // Receiver holds off while the sender keeps offering words.
   task automatic test_backpressure();
      hold_off_cycles = 4000;
      for (int i = 0; i < 12; i++) query_cell($urandom_range(64, 1), $urandom_range(64, 1));
   endtask

   task automatic test_idle_phases();
      send_idle_pct = 74; recv_stall_pct = 0;  test_random(120);
      send_idle_pct = 0;  recv_stall_pct = 74; test_random(120);
      send_idle_pct = 16; recv_stall_pct = 16; test_random(120);
      send_idle_pct = 0;  recv_stall_pct = 0;  test_random(120);
   endtask

   initial begin
      for (int i = 0; i < ONODES*INODES; i++) shadow_tags[i] = '0;
      rows_reg = SIZE_RESET;
      cols_reg = SIZE_RESET;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(60);
      test_backpressure();
      test_idle_phases();
      test_sizes();
      drain();
      if (mismatch_count == 0 && cell_values_due.size() == 0)
         $display("PASS grid_range_add_point_query_core");
      else
         $display("FAIL grid_range_add_point_query_core");
      $finish;
   end

endmodule
`default_nettype wire
